FILE: hw/rtl/pwa_pkg.sv
// ----------------------------------------------------------------------------
// pwa_pkg
// Shared types and constants of the pulse width averager.
// ----------------------------------------------------------------------------
package pwa_pkg;

    // time and tally sizes
    localparam int TIME_BITS  = 32;
    localparam int TALLY_BITS = 16;

    // fixed field widths
    localparam int CFG_BITS   = 16;
    localparam int SUB_BITS   = 16;
    localparam int SUM_BITS   = 32;
    localparam int AVG_BITS   = 32;
    localparam int SEEN_BITS  = 16;

    // shared adder covers both time and sum arithmetic
    localparam int ALU_BITS   = (TIME_BITS > SUM_BITS) ? TIME_BITS : SUM_BITS;

    // width used to saturate the tally into pulses_seen
    localparam int SAT_BITS   = (TALLY_BITS > SEEN_BITS) ? TALLY_BITS : SEEN_BITS;

    // divider: one quotient bit per step
    localparam int DIV_STEPS    = SUM_BITS;
    localparam int DIV_CNT_BITS = $clog2(DIV_STEPS + 1);

    // stream packing
    localparam int S_FIELD_BITS = 1 + SUB_BITS;
    localparam int S_TDATA_BITS = ((S_FIELD_BITS + 7) / 8) * 8;
    localparam int M_FIELD_BITS = AVG_BITS + SEEN_BITS;
    localparam int M_TDATA_BITS = ((M_FIELD_BITS + 7) / 8) * 8;

    // configuration port
    localparam int CFG_INDEX_BITS = 1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_TICK_INCREMENT = 1'b0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_WINDOW_TICKS   = 1'b1;

    localparam logic [CFG_BITS-1:0] TICK_INCREMENT_RESET = 16'd1000;
    localparam logic [CFG_BITS-1:0] WINDOW_TICKS_RESET   = 16'd1000;

    // item kinds
    localparam logic OP_TICK = 1'b0;
    localparam logic OP_EDGE = 1'b1;

    // pin levels
    localparam logic LEVEL_HIGH = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EDGE_WIDTH,
        ST_EDGE_SUM,
        ST_DIVIDE,
        ST_DELIVER
    } pwa_state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

endpackage

FILE: hw/rtl/pwa_divider.sv
// ----------------------------------------------------------------------------
// pwa_divider
// Restoring divider: width sum over pulse tally, one quotient bit a cycle.
// ----------------------------------------------------------------------------
module pwa_divider
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [pwa_pkg::SUM_BITS-1:0]   dividend,
    input  logic [pwa_pkg::TALLY_BITS-1:0] divisor,
    output pwa_pkg::div_status_t           stat,
    output logic [pwa_pkg::SUM_BITS-1:0]   quotient
);
    import pwa_pkg::*;

    logic                    busy_reg;
    logic                    done_reg;
    logic [DIV_CNT_BITS-1:0] count_reg;
    logic [TALLY_BITS-1:0]   rem_reg;
    logic [SUM_BITS-1:0]     quo_reg;
    logic [TALLY_BITS-1:0]   divisor_reg;

    logic [TALLY_BITS:0]     shifted;
    logic [TALLY_BITS+1:0]   diff;
    logic                    borrow;

    // trial subtract of the divisor from the shifted remainder
    always_comb
    begin
        shifted = {rem_reg, quo_reg[SUM_BITS-1]};
        diff    = {1'b0, shifted} - {2'b00, divisor_reg};
        borrow  = diff[TALLY_BITS+1];
    end

    // step control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg  <= 1'b1;
                count_reg <= DIV_CNT_BITS'(DIV_STEPS);
            end
            else if (busy_reg)
            begin
                count_reg <= count_reg - 1'b1;
                if (count_reg == DIV_CNT_BITS'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // remainder and quotient shift
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg     <= '0;
            quo_reg     <= dividend;
            divisor_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= borrow ? shifted[TALLY_BITS-1:0] : diff[TALLY_BITS-1:0];
            quo_reg <= {quo_reg[SUM_BITS-2:0], ~borrow};
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = quo_reg;

endmodule

FILE: hw/rtl/pulse_width_averager.sv
// ----------------------------------------------------------------------------
// pulse_width_averager
// Measures high-pulse widths from edge beats and reports their window average.
// ----------------------------------------------------------------------------
// Input stream (s_*): one beat per timer tick (s_tuser = 0) or per pin edge
// (s_tuser = 1, with the pin level and the sub-tick microsecond counter).
// Output stream (m_*): one beat at the end of each window of ticks, carrying
// the average pulse width and the number of pulses seen in that window.
// Configuration: cfg_we/cfg_index/cfg_data write tick_increment (index 0)
// and window_ticks (index 1); write only while the block is idle.
// Sequencing: ticks and rising edges are taken in the idle state; a falling
// edge that closes a pulse passes the width and sum states, as the one shared
// adder forms the edge time, the width and the new sum in turn. A tick that
// ends a window with pulses runs the 32-step restoring divider, then deliver;
// an empty window goes to deliver. s_tready is high only in the idle state.
// Reset: clears time, sum, tally and average, loads both registers and the
// window count with 1000, and drops m_tvalid.
// Stall: a finished result sits in the output register while new beats are
// taken; a second result waits in the sequencer until the first is taken.
// ----------------------------------------------------------------------------
module pulse_width_averager
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    // configuration writes
    input  logic                                 cfg_we,
    input  logic [pwa_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  logic [pwa_pkg::CFG_BITS-1:0]         cfg_data,
    // input beats
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [pwa_pkg::S_TDATA_BITS-1:0]     s_tdata,  // pin_level, sub_tick_count, pad
    input  logic                                 s_tuser,  // opcode
    // result beats
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [pwa_pkg::M_TDATA_BITS-1:0]     m_tdata   // average_width, pulses_seen
);
    import pwa_pkg::*;

    pwa_state_t state_reg;
    pwa_state_t state_next;

    logic [CFG_BITS-1:0]   tick_inc_reg;
    logic [CFG_BITS-1:0]   window_ticks_reg;
    logic [TIME_BITS-1:0]  elapsed_reg;
    logic [TIME_BITS-1:0]  pulse_start_reg;
    logic                  in_pulse_reg;
    logic [SUM_BITS-1:0]   width_sum_reg;
    logic [TALLY_BITS-1:0] tally_reg;
    logic [CFG_BITS-1:0]   window_left_reg;
    logic [AVG_BITS-1:0]   last_avg_reg;
    logic [TALLY_BITS-1:0] seen_reg;
    logic [TIME_BITS-1:0]  time_tmp_reg;
    logic                  m_tvalid_reg;
    logic [AVG_BITS-1:0]   out_avg_reg;
    logic [SEEN_BITS-1:0]  out_seen_reg;

    // input fields
    logic                  in_level;
    logic [SUB_BITS-1:0]   in_sub;
    logic                  accept;
    logic                  tick_fire;
    logic                  edge_fire;

    // shared adder
    logic [ALU_BITS-1:0]   alu_a;
    logic [ALU_BITS-1:0]   alu_b;
    logic                  alu_sub;
    logic [ALU_BITS-1:0]   alu_y;

    // tick window logic
    logic [CFG_BITS-1:0]   window_dec;
    logic                  window_end;
    logic                  rise_start;
    logic                  fall_close;

    // sequencer outputs
    logic                  div_start;
    logic                  deliver_fire;
    logic [SEEN_BITS-1:0]  seen_sat;

    div_status_t           div_stat;
    logic [SUM_BITS-1:0]   div_quotient;

    assign in_level  = s_tdata[0];
    assign in_sub    = s_tdata[SUB_BITS:1];
    assign accept    = s_tvalid && s_tready;
    assign tick_fire = accept && (s_tuser == OP_TICK);
    assign edge_fire = accept && (s_tuser == OP_EDGE);

    // window countdown, stops at zero
    assign window_dec = (window_left_reg != '0) ? (window_left_reg - 1'b1) : '0;
    assign window_end = (window_dec == '0);

    assign rise_start = (in_level == LEVEL_HIGH) && !in_pulse_reg;
    assign fall_close = (in_level != LEVEL_HIGH) && in_pulse_reg;

    // saturate tally into the 16-bit field
    assign seen_sat = (SAT_BITS'(seen_reg) > SAT_BITS'({SEEN_BITS{1'b1}}))
                    ? {SEEN_BITS{1'b1}} : SEEN_BITS'(seen_reg);

    // shared add/subtract unit
    assign alu_y = alu_a + (alu_sub ? ~alu_b : alu_b) + ALU_BITS'(alu_sub);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (tick_fire && window_end)
                begin
                    state_next = (tally_reg != '0) ? ST_DIVIDE : ST_DELIVER;
                end
                else if (edge_fire && fall_close)
                begin
                    state_next = ST_EDGE_WIDTH;
                end
            end
            ST_EDGE_WIDTH:
            begin
                state_next = ST_EDGE_SUM;
            end
            ST_EDGE_SUM:
            begin
                state_next = ST_IDLE;
            end
            ST_DIVIDE:
            begin
                if (div_stat.done)
                begin
                    state_next = ST_DELIVER;
                end
            end
            ST_DELIVER:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // sequencer outputs and adder operands
    always_comb
    begin
        s_tready     = 1'b0;
        div_start    = 1'b0;
        deliver_fire = 1'b0;
        alu_a        = ALU_BITS'(elapsed_reg);
        alu_b        = ALU_BITS'(tick_inc_reg);
        alu_sub      = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready  = 1'b1;
                div_start = tick_fire && window_end && (tally_reg != '0);
                if (s_tuser == OP_EDGE)
                begin
                    alu_b = ALU_BITS'(in_sub);
                end
            end
            ST_EDGE_WIDTH:
            begin
                alu_a   = ALU_BITS'(time_tmp_reg);
                alu_b   = ALU_BITS'(pulse_start_reg);
                alu_sub = 1'b1;
            end
            ST_EDGE_SUM:
            begin
                alu_a = ALU_BITS'(width_sum_reg);
                alu_b = ALU_BITS'(time_tmp_reg);
            end
            ST_DIVIDE:
            begin
                alu_a = ALU_BITS'(elapsed_reg);
            end
            ST_DELIVER:
            begin
                deliver_fire = !m_tvalid_reg || m_tready;
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_inc_reg     <= TICK_INCREMENT_RESET;
            window_ticks_reg <= WINDOW_TICKS_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_TICK_INCREMENT: tick_inc_reg     <= cfg_data;
                REG_WINDOW_TICKS:   window_ticks_reg <= cfg_data;
                default:            tick_inc_reg     <= tick_inc_reg;
            endcase
        end
    end

    // measurement state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            elapsed_reg     <= '0;
            pulse_start_reg <= '0;
            in_pulse_reg    <= 1'b0;
            width_sum_reg   <= '0;
            tally_reg       <= '0;
            window_left_reg <= WINDOW_TICKS_RESET;
            last_avg_reg    <= '0;
        end
        else
        begin
            // tick: advance time, count window, close window
            if (tick_fire)
            begin
                elapsed_reg <= TIME_BITS'(alu_y);
                if (window_end)
                begin
                    width_sum_reg   <= '0;
                    tally_reg       <= '0;
                    window_left_reg <= window_ticks_reg;
                end
                else
                begin
                    window_left_reg <= window_dec;
                end
            end
            // rising edge opens a pulse at the edge time
            if (edge_fire && rise_start)
            begin
                pulse_start_reg <= TIME_BITS'(alu_y);
                in_pulse_reg    <= 1'b1;
            end
            // falling edge: add width, bump saturating tally
            if (state_reg == ST_EDGE_SUM)
            begin
                width_sum_reg <= SUM_BITS'(alu_y);
                in_pulse_reg  <= 1'b0;
                if (tally_reg != {TALLY_BITS{1'b1}})
                begin
                    tally_reg <= tally_reg + 1'b1;
                end
            end
            if ((state_reg == ST_DIVIDE) && div_stat.done)
            begin
                last_avg_reg <= AVG_BITS'(div_quotient);
            end
        end
    end

    // scratch time and window tally snapshot
    always_ff @(posedge clk)
    begin
        if ((edge_fire && fall_close) || (state_reg == ST_EDGE_WIDTH))
        begin
            time_tmp_reg <= TIME_BITS'(alu_y);
        end
        if (tick_fire && window_end)
        begin
            seen_reg <= tally_reg;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (deliver_fire)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (deliver_fire)
        begin
            out_avg_reg  <= last_avg_reg;
            out_seen_reg <= seen_sat;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = M_TDATA_BITS'({out_seen_reg, out_avg_reg});

    // divider for the window average
    pwa_divider u_divider
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (width_sum_reg),
        .divisor  (tally_reg),
        .stat     (div_stat),
        .quotient (div_quotient)
    );

    // input beats only reach an idle divider
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> !div_stat.busy)
        else $error("input beat taken while divider busy");

    // a result beat only appears out of the deliver step
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid_reg) |-> $past(state_reg == ST_DELIVER))
        else $error("result beat raised outside deliver");

    // a pulse closes only through the sum update
    assert property (@(posedge clk) disable iff (!rst_n)
        $fell(in_pulse_reg) |-> $past(state_reg == ST_EDGE_SUM))
        else $error("pulse closed without sum update");

    // divider runs only while the sequencer waits on it
    assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.busy |-> (state_reg == ST_DIVIDE))
        else $error("divider busy outside divide step");

endmodule

FILE: bench/pwa_report_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwa_report_checker
// Watches the configuration port and both streams of the pulse width
// averager, keeps its own copy of the pulse timing state, queues the window
// report that each accepted tick ending a window should produce and compares
// every result beat against the oldest queued report.
// ----------------------------------------------------------------------------
module pwa_report_checker
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [pwa_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  logic [pwa_pkg::CFG_BITS-1:0]         cfg_data,
    input  logic                                 s_tvalid,
    input  logic                                 s_tready,
    input  logic [pwa_pkg::S_TDATA_BITS-1:0]     s_tdata,  // pin_level, sub_tick_count, pad
    input  logic                                 s_tuser,  // opcode
    input  logic                                 m_tvalid,
    input  logic                                 m_tready,
    input  logic [pwa_pkg::M_TDATA_BITS-1:0]     m_tdata,  // average_width, pulses_seen
    output int                                   pending,
    output int                                   mismatches
);
    import pwa_pkg::*;

    typedef struct packed {
        logic [AVG_BITS-1:0]  average_width;
        logic [SEEN_BITS-1:0] pulses_seen;
    } window_report_t;

    // register copies
    logic [CFG_BITS-1:0]   tick_step;
    logic [CFG_BITS-1:0]   window_len;

    // pulse timing state
    logic [TIME_BITS-1:0]  clock_us;
    logic [TIME_BITS-1:0]  rise_stamp;
    logic                  pulse_open;
    logic [SUM_BITS-1:0]   width_total;
    logic [TALLY_BITS-1:0] closed_pulses;
    logic [CFG_BITS-1:0]   ticks_left;
    logic [AVG_BITS-1:0]   average_us;

    window_report_t        due_reports[$];
    window_report_t        wanted;
    window_report_t        seen_beat;

    // register write
    task automatic apply_register(input logic [CFG_INDEX_BITS-1:0] idx,
                                  input logic [CFG_BITS-1:0] value);
        case (idx)
            REG_TICK_INCREMENT: tick_step  = value;
            REG_WINDOW_TICKS:   window_len = value;
            default: ;
        endcase
    endtask

    // advance the pulse timing state by one input beat
    task automatic absorb_beat(input logic op, input logic level,
                               input logic [SUB_BITS-1:0] sub);
        logic [TIME_BITS-1:0] stamp;
        logic [TIME_BITS-1:0] span;
        window_report_t       report;
        if (op == OP_EDGE) begin
            stamp = clock_us + sub;
            if (level == LEVEL_HIGH) begin
                // a second rising edge inside a pulse is ignored
                if (!pulse_open) begin
                    rise_stamp = stamp;
                    pulse_open = 1'b1;
                end
            end
            else if (pulse_open) begin
                span        = stamp - rise_stamp;
                width_total = width_total + span[SUM_BITS-1:0];
                if (closed_pulses != {TALLY_BITS{1'b1}})
                    closed_pulses = closed_pulses + 1'b1;
                pulse_open  = 1'b0;
            end
        end
        else begin
            if (ticks_left != '0)
                ticks_left = ticks_left - 1'b1;
            clock_us = clock_us + tick_step;
            // window end: report, clear and reload
            if (ticks_left == '0) begin
                if (closed_pulses != '0)
                    average_us = width_total / closed_pulses;
                report.average_width = average_us;
                report.pulses_seen   = (closed_pulses > {SEEN_BITS{1'b1}}) ?
                                       {SEEN_BITS{1'b1}} : closed_pulses[SEEN_BITS-1:0];
                due_reports.push_back(report);
                width_total   = '0;
                closed_pulses = '0;
                ticks_left    = window_len;
            end
        end
    endtask

    // compare one result beat with the oldest queued report
    task automatic check_report(input logic [M_TDATA_BITS-1:0] beat);
        seen_beat.average_width = beat[AVG_BITS-1:0];
        seen_beat.pulses_seen   = beat[AVG_BITS +: SEEN_BITS];
        if (due_reports.size() == 0) begin
            $error("unexpected result beat: average_width %0d, pulses_seen %0d",
                   seen_beat.average_width, seen_beat.pulses_seen);
            mismatches++;
        end
        else begin
            wanted = due_reports.pop_front();
            if (seen_beat.average_width !== wanted.average_width) begin
                $error("average_width: expected %0d, actual %0d",
                       wanted.average_width, seen_beat.average_width);
                mismatches++;
            end
            if (seen_beat.pulses_seen !== wanted.pulses_seen) begin
                $error("pulses_seen: expected %0d, actual %0d",
                       wanted.pulses_seen, seen_beat.pulses_seen);
                mismatches++;
            end
        end
    endtask

    // channel monitor
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            tick_step     = TICK_INCREMENT_RESET;
            window_len    = WINDOW_TICKS_RESET;
            clock_us      = '0;
            rise_stamp    = '0;
            pulse_open    = 1'b0;
            width_total   = '0;
            closed_pulses = '0;
            ticks_left    = WINDOW_TICKS_RESET;
            average_us    = '0;
            due_reports.delete();
            pending       = 0;
            mismatches    = 0;
        end
        else begin
            if (m_tvalid && m_tready)
                check_report(m_tdata);
            if (cfg_we)
                apply_register(cfg_index, cfg_data);
            if (s_tvalid && s_tready)
                absorb_beat(s_tuser, s_tdata[0], s_tdata[SUB_BITS:1]);
            pending = due_reports.size();
        end
    end

endmodule

FILE: bench/tb_pulse_width_averager.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_pulse_width_averager
// Drives tick and edge beats into the pulse width averager under several
// register settings and stall patterns; the report checker judges every
// result beat.
// ----------------------------------------------------------------------------
module tb_pulse_width_averager;
    import pwa_pkg::*;

    localparam int   SETTLE_CYCLES     = 48;
    localparam int   WATCHDOG_LIMIT    = 5000;
    localparam int   PHASE_ITEMS       = 230;
    localparam logic LEVEL_LOW         = ~LEVEL_HIGH;

    logic                        clk;
    logic                        rst_n     = 1'b0;
    logic                        cfg_we    = 1'b0;
    logic [CFG_INDEX_BITS-1:0]   cfg_index = '0;
    logic [CFG_BITS-1:0]         cfg_data  = '0;
    logic                        s_tvalid  = 1'b0;
    logic                        s_tready;
    logic [S_TDATA_BITS-1:0]     s_tdata   = '0;  // pin_level, sub_tick_count, pad
    logic                        s_tuser   = 1'b0;  // opcode
    logic                        m_tvalid;
    logic                        m_tready  = 1'b0;
    logic [M_TDATA_BITS-1:0]     m_tdata;  // average_width, pulses_seen

    int pending;
    int mismatches;
    int tx_idle_pct = 15;
    int rx_idle_pct = 55;
    int quiet_cycles;

    pulse_width_averager u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    pwa_report_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .pending    (pending),
        .mismatches (mismatches)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // receiver stalls
    always @(posedge clk)
    begin
        m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end

    // watchdog on cycles without any accepted beat
    initial
    begin
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("CHECK FAILED");
        $finish;
    end

    // one input beat, with random idle cycles ahead of it
    task automatic send_item(input logic op, input logic level,
                             input logic [SUB_BITS-1:0] sub);
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {{(S_TDATA_BITS - S_FIELD_BITS){1'b0}}, sub, level};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    // tick with random don't-care fields
    task automatic send_tick();
        send_item(OP_TICK, 1'($urandom_range(0, 1)), 16'($urandom_range(0, 65535)));
    endtask

    task automatic send_edge(input logic level, input logic [SUB_BITS-1:0] sub);
        send_item(OP_EDGE, level, sub);
    endtask

    // stop sending until every queued report has come out
    task automatic quiesce();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    // register write while idle
    task automatic write_register(input logic [CFG_INDEX_BITS-1:0] idx,
                                  input logic [CFG_BITS-1:0] value);
        quiesce();
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // mostly well-formed pulses with ticks around them, some stray edges
    task automatic run_traffic(input int count);
        int sent;
        int roll;
        int span_ticks;
        int gap_ticks;
        sent = 0;
        while (sent < count)
        begin
            roll = $urandom_range(0, 99);
            if (roll == 0)
                quiesce();
            if (roll < 75)
            begin
                span_ticks = $urandom_range(0, 2);
                gap_ticks  = $urandom_range(0, 3);
                send_edge(LEVEL_HIGH, 16'($urandom_range(0, 65535)));
                repeat (span_ticks) send_tick();
                send_edge(LEVEL_LOW, 16'($urandom_range(0, 65535)));
                repeat (gap_ticks) send_tick();
                sent += 2 + span_ticks + gap_ticks;
            end
            else if (roll < 90)
            begin
                send_edge(1'($urandom_range(0, 1)), 16'($urandom_range(0, 65535)));
                sent++;
            end
            else
            begin
                send_tick();
                sent++;
            end
        end
    endtask

    // stimulus and verdict
    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: stray falling edge, repeated rising edge, wrapped width
        send_edge(LEVEL_LOW, 16'h1234);
        send_edge(LEVEL_HIGH, 16'hFFFF);
        send_edge(LEVEL_HIGH, 16'h0000);
        send_tick();
        send_edge(LEVEL_LOW, 16'h0000);
        send_edge(LEVEL_HIGH, 16'h0000);
        send_edge(LEVEL_LOW, 16'hFFFF);
        send_item(OP_TICK, LEVEL_HIGH, 16'hFFFF);

        // largest step, zero window reload after the first window
        write_register(REG_TICK_INCREMENT, 16'hFFFF);
        write_register(REG_WINDOW_TICKS, 16'h0000);
        send_edge(LEVEL_HIGH, 16'd100);
        send_tick();
        send_edge(LEVEL_LOW, 16'd50);
        repeat (997) send_tick();

        // zero window: every tick reports, empty windows repeat the average
        send_tick();
        send_tick();
        send_edge(LEVEL_HIGH, 16'h0000);
        send_edge(LEVEL_LOW, 16'hFFFF);
        send_tick();
        send_tick();

        // sender idles lightly, receiver heavily
        write_register(REG_TICK_INCREMENT, 16'($urandom_range(1, 65535)));
        write_register(REG_WINDOW_TICKS, 16'd3);
        run_traffic(PHASE_ITEMS);

        // roles swapped, smallest step
        tx_idle_pct = 55;
        rx_idle_pct = 15;
        write_register(REG_TICK_INCREMENT, 16'd1);
        write_register(REG_WINDOW_TICKS, 16'd9);
        run_traffic(PHASE_ITEMS);

        // no idling, one-tick windows
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        write_register(REG_TICK_INCREMENT, 16'($urandom_range(1, 65535)));
        write_register(REG_WINDOW_TICKS, 16'd1);
        run_traffic(PHASE_ITEMS);

        // drain
        quiesce();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0 && pending == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

FILE: filelist.f
hw/rtl/pwa_pkg.sv
hw/rtl/pwa_divider.sv
hw/rtl/pulse_width_averager.sv
bench/pwa_report_checker.sv
bench/tb_pulse_width_averager.sv
